// File: sv/fsg_pkg.sv
`default_nettype none
package fsg_pkg;

    localparam int GRID_MAX = 64;
    localparam int COORD_W  = $clog2(GRID_MAX);
    localparam int SIDE_W   = $clog2(GRID_MAX + 1);
    localparam int ADDR_W   = 2 * COORD_W;
    localparam int DEPTH    = GRID_MAX * GRID_MAX;
    localparam int SIZE_W   = 7;
    localparam int KIND_W   = 2;
    localparam int MODE_W   = 2;

    localparam logic [SIZE_W-1:0] GRID_SIZE_RESET = SIZE_W'(40);

    localparam logic [KIND_W-1:0] KIND_EMPTY    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SAND     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_OBSTACLE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNDEF    = 2'd3;

    localparam logic [MODE_W-1:0] MODE_PLACE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FRAME = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [COORD_W-1:0] x_coord;
        logic [COORD_W-1:0] y_coord;
        logic [KIND_W-1:0]  cell_kind;
    } req_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind_read;
        logic              coord_valid;
    } rsp_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [KIND_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_ctrl_t;

endpackage
`default_nettype wire

// File: sv/fsg_if.sv
`default_nettype none
interface fsg_req_if;
    logic                          valid;
    logic                          ready;
    logic [fsg_pkg::MODE_W-1:0]    mode;
    logic [fsg_pkg::COORD_W-1:0]   x_coord;
    logic [fsg_pkg::COORD_W-1:0]   y_coord;
    logic [fsg_pkg::KIND_W-1:0]    cell_kind;

    modport source (output valid, mode, x_coord, y_coord, cell_kind, input ready);
    modport sink   (input valid, mode, x_coord, y_coord, cell_kind, output ready);
endinterface

interface fsg_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [fsg_pkg::KIND_W-1:0]    kind_read;
    logic                          coord_valid;

    modport source (output valid, kind_read, coord_valid, input ready);
    modport sink   (input valid, kind_read, coord_valid, output ready);
endinterface
`default_nettype wire

// File: sv/fsg_ram.sv
`default_nettype none
module fsg_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// File: sv/fsg_engine.sv
`default_nettype none
module fsg_engine (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [fsg_pkg::SIZE_W-1:0]    grid_size,
    input  wire logic                          req_valid,
    input  wire fsg_pkg::req_t                 req_data,
    output logic                               req_ready,
    output logic                               done,
    output fsg_pkg::rsp_t                      result,
    input  wire logic                          out_free,
    output fsg_pkg::ram_ctrl_t                 ram_ctrl,
    input  wire logic [fsg_pkg::KIND_W-1:0]    ram_rdata
);

    localparam int CW = fsg_pkg::COORD_W;
    localparam int SW = fsg_pkg::SIDE_W;
    localparam int GM = fsg_pkg::GRID_MAX;

    localparam logic [1:0] DIR_DOWN  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;

    typedef enum logic [8:0] {
        ST_CLEAR   = 9'b000000001,
        ST_IDLE    = 9'b000000010,
        ST_RD_WAIT = 9'b000000100,
        ST_F_HERE  = 9'b000001000,
        ST_F_CHK   = 9'b000010000,
        ST_F_NB    = 9'b000100000,
        ST_F_NBCHK = 9'b001000000,
        ST_F_MOVE  = 9'b010000000,
        ST_DONE    = 9'b100000000
    } state_t;

    state_t                        state_reg, state_next;
    logic [fsg_pkg::ADDR_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [CW-1:0]                 x_reg, x_next;
    logic [CW-1:0]                 y_reg, y_next;
    logic [CW-1:0]                 nx_reg, nx_next;
    logic [SW-1:0]                 n_reg, n_next;
    logic [1:0]                    dir_reg, dir_next;
    logic [GM-1:0]                 cur_mark_reg, cur_mark_next;
    logic [GM-1:0]                 nxt_mark_reg, nxt_mark_next;
    fsg_pkg::rsp_t                 res_reg, res_next;

    logic [SW-1:0] side;
    logic          in_grid;
    logic [SW-1:0] x_plus;
    logic [SW-1:0] y_plus;
    logic [SW-1:0] nb_x;
    logic          nb_ok;
    logic          adv;

    // saturate the register at the largest grid
    assign side    = (grid_size > fsg_pkg::SIZE_W'(GM)) ? SW'(GM) : SW'(grid_size);
    assign in_grid = ({1'b0, req_data.x_coord} < side) && ({1'b0, req_data.y_coord} < side);
    assign x_plus  = {1'b0, x_reg} + SW'(1);
    assign y_plus  = {1'b0, y_reg} + SW'(1);

    always_comb
    begin
        nb_x  = {1'b0, x_reg};
        nb_ok = 1'b1;
        case (dir_reg)
            DIR_RIGHT:
            begin
                nb_x  = x_plus;
                nb_ok = x_plus < n_reg;
            end
            DIR_LEFT:
            begin
                nb_x  = {1'b0, x_reg} - SW'(1);
                nb_ok = x_reg != '0;
            end
            default:
            begin
                nb_x  = {1'b0, x_reg};
                nb_ok = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        nx_next       = nx_reg;
        n_next        = n_reg;
        dir_next      = dir_reg;
        cur_mark_next = cur_mark_reg;
        nxt_mark_next = nxt_mark_reg;
        res_next      = res_reg;
        ram_ctrl      = '0;
        ram_ctrl.raddr = {y_reg, x_reg};
        adv           = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_ctrl.we    = 1'b1;
                ram_ctrl.waddr = clr_cnt_reg;
                ram_ctrl.wdata = fsg_pkg::KIND_EMPTY;
                clr_cnt_next   = clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                ram_ctrl.raddr = {req_data.y_coord, req_data.x_coord};
                if (req_valid)
                begin
                    n_next   = side;
                    res_next = '0;
                    unique case (req_data.mode)
                        fsg_pkg::MODE_PLACE:
                        begin
                            ram_ctrl.we    = in_grid &&
                                             (req_data.cell_kind != fsg_pkg::KIND_UNDEF);
                            ram_ctrl.waddr = {req_data.y_coord, req_data.x_coord};
                            ram_ctrl.wdata = req_data.cell_kind;
                            res_next.coord_valid = in_grid;
                            state_next = ST_DONE;
                        end
                        fsg_pkg::MODE_READ:
                        begin
                            res_next.coord_valid = in_grid;
                            state_next = in_grid ? ST_RD_WAIT : ST_DONE;
                        end
                        fsg_pkg::MODE_FRAME:
                        begin
                            res_next.coord_valid = 1'b1;
                            x_next        = '0;
                            y_next        = '0;
                            cur_mark_next = '0;
                            nxt_mark_next = '0;
                            state_next    = (side == '0) ? ST_DONE : ST_F_HERE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_RD_WAIT:
            begin
                res_next.kind_read = ram_rdata;
                state_next = ST_DONE;
            end
            ST_F_HERE:
            begin
                state_next = ST_F_CHK;
            end
            ST_F_CHK:
            begin
                // only an unmoved grain above the bottom row can fall
                if ((ram_rdata == fsg_pkg::KIND_SAND) && !cur_mark_reg[x_reg] &&
                    (y_plus < n_reg))
                begin
                    dir_next   = DIR_DOWN;
                    state_next = ST_F_NB;
                end
                else
                begin
                    adv = 1'b1;
                end
            end
            ST_F_NB:
            begin
                if (nb_ok)
                begin
                    ram_ctrl.raddr = {y_plus[CW-1:0], nb_x[CW-1:0]};
                    nx_next        = nb_x[CW-1:0];
                    state_next     = ST_F_NBCHK;
                end
                else if (dir_reg == DIR_LEFT)
                begin
                    adv = 1'b1;
                end
                else
                begin
                    dir_next = dir_reg + 2'd1;
                end
            end
            ST_F_NBCHK:
            begin
                if (ram_rdata == fsg_pkg::KIND_EMPTY)
                begin
                    ram_ctrl.we           = 1'b1;
                    ram_ctrl.waddr        = {y_plus[CW-1:0], nx_reg};
                    ram_ctrl.wdata        = fsg_pkg::KIND_SAND;
                    nxt_mark_next[nx_reg] = 1'b1;
                    state_next            = ST_F_MOVE;
                end
                else if (dir_reg == DIR_LEFT)
                begin
                    adv = 1'b1;
                end
                else
                begin
                    dir_next   = dir_reg + 2'd1;
                    state_next = ST_F_NB;
                end
            end
            ST_F_MOVE:
            begin
                ram_ctrl.we    = 1'b1;
                ram_ctrl.waddr = {y_reg, x_reg};
                ram_ctrl.wdata = fsg_pkg::KIND_EMPTY;
                adv            = 1'b1;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // step to the next cell; marks roll down one row with the sweep
        if (adv)
        begin
            if (x_plus < n_reg)
            begin
                x_next     = x_plus[CW-1:0];
                state_next = ST_F_HERE;
            end
            else if (y_plus < n_reg)
            begin
                x_next        = '0;
                y_next        = y_plus[CW-1:0];
                cur_mark_next = nxt_mark_reg;
                nxt_mark_next = '0;
                state_next    = ST_F_HERE;
            end
            else
            begin
                state_next = ST_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        nx_reg       <= nx_next;
        n_reg        <= n_next;
        dir_reg      <= dir_next;
        cur_mark_reg <= cur_mark_next;
        nxt_mark_reg <= nxt_mark_next;
        res_reg      <= res_next;
    end

    assign req_ready = state_reg == ST_IDLE;
    assign done      = state_reg == ST_DONE;
    assign result    = res_reg;

endmodule
`default_nettype wire

// File: sv/falling_sand_grid_step.sv
`default_nettype none
// Falling-sand grid engine.
//
// Requests arrive on the req channel (valid/ready): place a kind at (x, y),
// read the kind at (x, y), or advance the whole grid by one frame. Every
// request produces exactly one response on the rsp channel (valid/ready)
// carrying kind_read and coord_valid.
// The grid side is set by cfg_we/cfg_wdata; write it only while idle.
//
// A place writes its cell as it is accepted; an in-grid read waits a
// state for the cell memory. A frame walks the active n x n grid through
// the cell memory's one read and one write port: each unmoved grain above
// the bottom row tries below, below-right, then below-left, moves to the
// first empty one and empties its old cell. One request is in flight at
// a time; req.ready drops from acceptance until the response is loaded.
// After reset the cell memory is swept to empty, one cell per cycle over
// all 4096 cells; req.ready stays low during the sweep.
// A stalled response waits in the output register; the block may take the
// next request meanwhile and holds its result until the register frees.
module falling_sand_grid_step (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [fsg_pkg::SIZE_W-1:0] cfg_wdata,
    fsg_req_if.sink                         req,
    fsg_rsp_if.source                       rsp
);

    logic [fsg_pkg::SIZE_W-1:0] grid_size_reg;
    logic                       out_valid_reg;
    fsg_pkg::rsp_t              out_data_reg;

    fsg_pkg::req_t              req_data;
    fsg_pkg::rsp_t              eng_result;
    fsg_pkg::ram_ctrl_t         ram_ctrl;
    logic [fsg_pkg::KIND_W-1:0] ram_rdata;
    logic                       eng_done;
    logic                       out_free;

    // hold the grid side; values above the grid maximum saturate in the engine
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg <= fsg_pkg::GRID_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            grid_size_reg <= cfg_wdata;
        end
    end

    assign req_data.mode      = req.mode;
    assign req_data.x_coord   = req.x_coord;
    assign req_data.y_coord   = req.y_coord;
    assign req_data.cell_kind = req.cell_kind;

    fsg_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .grid_size (grid_size_reg),
        .req_valid (req.valid),
        .req_data  (req_data),
        .req_ready (req.ready),
        .done      (eng_done),
        .result    (eng_result),
        .out_free  (out_free),
        .ram_ctrl  (ram_ctrl),
        .ram_rdata (ram_rdata)
    );

    fsg_ram #(
        .WIDTH (fsg_pkg::KIND_W),
        .DEPTH (fsg_pkg::DEPTH)
    ) u_cells (
        .clk   (clk),
        .we    (ram_ctrl.we),
        .waddr (ram_ctrl.waddr),
        .wdata (ram_ctrl.wdata),
        .raddr (ram_ctrl.raddr),
        .rdata (ram_rdata)
    );

    // output register: free when empty or being drained this cycle
    assign out_free = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (eng_done && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eng_done && out_free)
        begin
            out_data_reg <= eng_result;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.kind_read   = out_data_reg.kind_read;
    assign rsp.coord_valid = out_data_reg.coord_valid;

    // a request always keeps the block busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request accepted while previous one still in work");

    // an outside-the-grid answer never carries a kind
    a_invalid_reads_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.coord_valid |-> rsp.kind_read == fsg_pkg::KIND_EMPTY)
        else $error("kind reported for coordinate outside the grid");

    // the undefined kind code never lands in the cell memory
    a_no_undef_write: assert property (@(posedge clk) disable iff (!rst_n)
        ram_ctrl.we |-> ram_ctrl.wdata != fsg_pkg::KIND_UNDEF)
        else $error("undefined kind written to cell memory");

    // a new response loads only when the output register is free
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !rsp.ready |=> out_valid_reg && $stable(out_data_reg))
        else $error("pending response overwritten");

endmodule
`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 100ps
module tb_top;

    // Mode code with no defined meaning; the block must answer it with zeros.
    localparam logic [fsg_pkg::MODE_W-1:0] MODE_UNDEF = 2'd3;
    // Generous bound on the length of the slowest correct run.
    localparam int CYCLE_LIMIT = 20_000_000;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [fsg_pkg::SIZE_W-1:0] cfg_wdata;

    fsg_req_if req_ch ();
    fsg_rsp_if rsp_ch ();

    falling_sand_grid_step dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    always #5 clk = ~clk;

    // Shadow copy of the grid, the per-frame fall marks and the size register.
    logic [fsg_pkg::KIND_W-1:0] sand_cells [fsg_pkg::DEPTH];
    bit                         fell_this_frame [fsg_pkg::DEPTH];
    logic [fsg_pkg::SIZE_W-1:0] side_reg;

    fsg_pkg::req_t requests_todo [$];   // requests waiting for the driver
    fsg_pkg::rsp_t answers_due   [$];   // predicted answers, oldest first
    fsg_pkg::req_t head_req;
    fsg_pkg::rsp_t due;
    fsg_pkg::rsp_t predicted;

    int  queued_total   = 0;
    int  answered_total = 0;
    int  mismatches     = 0;
    int  cycle_count    = 0;
    int  frames_run     = 0;
    int  reads_run      = 0;
    int  places_run     = 0;
    int  sizes_written  = 0;
    int  req_gap;
    int  rsp_stall;
    int  rsp_draw;
    bit  req_took;
    bit  rsp_took;
    bit  req_idle_on    = 1'b1;
    bit  rsp_idle_on    = 1'b1;

    // Side length in use: the register saturates at the grid maximum.
    function automatic int side_now();
        return (int'(side_reg) > fsg_pkg::GRID_MAX) ? fsg_pkg::GRID_MAX : int'(side_reg);
    endfunction

    // A cell counts as vacant only if it lies inside the active grid.
    function automatic bit vacant(int x, int y, int n);
        if (x < 0 || x >= n || y >= n)
            return 1'b0;
        return sand_cells[y * fsg_pkg::GRID_MAX + x] == fsg_pkg::KIND_EMPTY;
    endfunction

    // Sweep rows top down, columns left to right; each grain not yet moved
    // drops to below, then below-right, then below-left.
    function automatic void settle_frame();
        int n;
        int x;
        int y;
        int here;
        int dest;
        n = side_now();
        for (y = 0; y < n; y++)
        begin
            for (x = 0; x < n; x++)
            begin
                here = y * fsg_pkg::GRID_MAX + x;
                if (sand_cells[here] == fsg_pkg::KIND_SAND && !fell_this_frame[here])
                begin
                    dest = -1;
                    if (vacant(x, y + 1, n))
                        dest = (y + 1) * fsg_pkg::GRID_MAX + x;
                    else if (vacant(x + 1, y + 1, n))
                        dest = (y + 1) * fsg_pkg::GRID_MAX + x + 1;
                    else if (x > 0 && vacant(x - 1, y + 1, n))
                        dest = (y + 1) * fsg_pkg::GRID_MAX + x - 1;
                    if (dest >= 0)
                    begin
                        sand_cells[here]      = fsg_pkg::KIND_EMPTY;
                        fell_this_frame[here] = 1'b0;
                        sand_cells[dest]      = fsg_pkg::KIND_SAND;
                        fell_this_frame[dest] = 1'b1;
                    end
                end
            end
        end
        for (here = 0; here < fsg_pkg::DEPTH; here++)
            fell_this_frame[here] = 1'b0;
    endfunction

    // Apply one accepted request to the shadow grid and return its answer.
    function automatic fsg_pkg::rsp_t apply_request(fsg_pkg::req_t r);
        fsg_pkg::rsp_t a;
        int            n;
        bit            in_grid;
        int            at;
        n       = side_now();
        in_grid = (int'(r.x_coord) < n) && (int'(r.y_coord) < n);
        at      = int'(r.y_coord) * fsg_pkg::GRID_MAX + int'(r.x_coord);
        a.kind_read   = fsg_pkg::KIND_EMPTY;
        a.coord_valid = 1'b0;
        case (r.mode)
            fsg_pkg::MODE_PLACE:
            begin
                places_run++;
                a.coord_valid = in_grid;
                if (in_grid && r.cell_kind != fsg_pkg::KIND_UNDEF)
                    sand_cells[at] = r.cell_kind;
            end
            fsg_pkg::MODE_FRAME:
            begin
                frames_run++;
                settle_frame();
                a.coord_valid = 1'b1;
            end
            fsg_pkg::MODE_READ:
            begin
                reads_run++;
                a.coord_valid = in_grid;
                if (in_grid)
                    a.kind_read = sand_cells[at];
            end
            default:
            begin
            end
        endcase
        return a;
    endfunction

    function automatic void enqueue_request(int m, int x, int y, int k);
        fsg_pkg::req_t r;
        r.mode      = fsg_pkg::MODE_W'(m);
        r.x_coord   = fsg_pkg::COORD_W'(x);
        r.y_coord   = fsg_pkg::COORD_W'(y);
        r.cell_kind = fsg_pkg::KIND_W'(k);
        requests_todo = {requests_todo, r};
        queued_total++;
    endfunction

    // Idle gap for one request or one response: none while the side is busy.
    function automatic int pick_gap(bit idle_on);
        return idle_on ? int'($urandom_range(0, 13)) : 0;
    endfunction

    // Mostly sand, so frames have grains to move.
    function automatic int pick_kind();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12)
            return fsg_pkg::KIND_SAND;
        if (r < 17)
            return fsg_pkg::KIND_OBSTACLE;
        return fsg_pkg::KIND_EMPTY;
    endfunction

    // Hold until every request has been answered, then let the block settle.
    task automatic wait_for_quiet();
        do
            @(negedge clk);
        while (answered_total != queued_total);
        repeat (4) @(negedge clk);
    endtask

    // Write the size register while the block is idle; track it in the shadow.
    task automatic set_grid_size(int value);
        wait_for_quiet();
        cfg_we    <= 1'b1;
        cfg_wdata <= fsg_pkg::SIZE_W'(value);
        side_reg  = fsg_pkg::SIZE_W'(value);
        sizes_written++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random traffic at one size: mostly place/frame/read sequences,
    // with a share of noise (bad modes, bad kinds, any coordinate).
    task automatic random_phase(int size, int items);
        int n;
        int start;
        set_grid_size(size);
        n     = (size > fsg_pkg::GRID_MAX) ? fsg_pkg::GRID_MAX : size;
        start = queued_total;
        while (queued_total - start < items)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                repeat ($urandom_range(1, 3))
                    enqueue_request($urandom_range(0, 3), $urandom_range(0, 63),
                                    $urandom_range(0, 63), $urandom_range(0, 3));
            end
            else
            begin
                repeat ($urandom_range(2, 5))
                    enqueue_request(fsg_pkg::MODE_PLACE, $urandom_range(0, n - 1),
                                    $urandom_range(0, n - 1), pick_kind());
                repeat ((n > 16) ? 1 : $urandom_range(1, 3))
                    enqueue_request(fsg_pkg::MODE_FRAME, $urandom_range(0, 63),
                                    $urandom_range(0, 63), $urandom_range(0, 3));
                repeat ($urandom_range(2, 4))
                    enqueue_request(fsg_pkg::MODE_READ, $urandom_range(0, n - 1),
                                    $urandom_range(n / 2, n - 1), $urandom_range(0, 3));
            end
        end
    endtask

    // Request driver: advance on the falling edge, hold a request until taken,
    // then wait its drawn gap before offering the next one.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_gap      <= 0;
        end
        else if (!req_ch.valid || req_took)
        begin
            if (req_gap != 0)
            begin
                req_ch.valid <= 1'b0;
                req_gap      <= req_gap - 1;
            end
            else if (requests_todo.size() != 0)
            begin
                head_req = requests_todo.pop_front();
                // Flip now and then between busy and idle stretches.
                if ($urandom_range(0, 15) == 0)
                    req_idle_on = !req_idle_on;
                req_ch.valid     <= 1'b1;
                req_ch.mode      <= head_req.mode;
                req_ch.x_coord   <= head_req.x_coord;
                req_ch.y_coord   <= head_req.y_coord;
                req_ch.cell_kind <= head_req.cell_kind;
                req_gap          <= pick_gap(req_idle_on);
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Response side: after each taken response, drop ready for a drawn stall.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            rsp_stall    <= 0;
        end
        else if (rsp_took)
        begin
            if ($urandom_range(0, 15) == 0)
                rsp_idle_on = !rsp_idle_on;
            rsp_draw = pick_gap(rsp_idle_on);
            rsp_ch.ready <= (rsp_draw == 0);
            rsp_stall    <= rsp_draw;
        end
        else if (rsp_stall != 0)
        begin
            rsp_stall    <= rsp_stall - 1;
            rsp_ch.ready <= (rsp_stall == 1);
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // Monitor: sample both handshakes on the rising edge, predict each taken
    // request and check each taken response against the oldest prediction.
    always @(posedge clk)
    begin
        cycle_count++;
        req_took = rst_n && req_ch.valid && req_ch.ready;
        rsp_took = rst_n && rsp_ch.valid && rsp_ch.ready;
        if (req_took)
        begin
            head_req.mode      = req_ch.mode;
            head_req.x_coord   = req_ch.x_coord;
            head_req.y_coord   = req_ch.y_coord;
            head_req.cell_kind = req_ch.cell_kind;
            predicted   = apply_request(head_req);
            answers_due = {answers_due, predicted};
        end
        if (rsp_took)
        begin
            if (answers_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: response with no request outstanding (kind_read %0d)",
                             $realtime, rsp_ch.kind_read);
            end
            else
            begin
                due = answers_due.pop_front();
                answered_total++;
                if (rsp_ch.kind_read !== due.kind_read
                        || rsp_ch.coord_valid !== due.coord_valid)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: rsp %0d kind exp %0d got %0d, valid exp %0d got %0d",
                                 $realtime, answered_total, due.kind_read,
                                 rsp_ch.kind_read, due.coord_valid, rsp_ch.coord_valid);
                end
            end
        end
    end

    // Watchdog: end the run if traffic stalls.
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int i;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        req_ch.valid     = 1'b0;
        req_ch.mode      = fsg_pkg::MODE_PLACE;
        req_ch.x_coord   = '0;
        req_ch.y_coord   = '0;
        req_ch.cell_kind = fsg_pkg::KIND_EMPTY;
        rsp_ch.ready     = 1'b0;
        side_reg         = fsg_pkg::GRID_SIZE_RESET;
        for (i = 0; i < fsg_pkg::DEPTH; i++)
        begin
            sand_cells[i]      = fsg_pkg::KIND_EMPTY;
            fell_this_frame[i] = 1'b0;
        end
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset size, corner cells, bad kind, bad mode, out of grid.
        enqueue_request(fsg_pkg::MODE_READ, 0, 0, fsg_pkg::KIND_EMPTY);
        enqueue_request(fsg_pkg::MODE_PLACE, 0, 0, fsg_pkg::KIND_SAND);
        enqueue_request(fsg_pkg::MODE_PLACE, 5, 5, fsg_pkg::KIND_OBSTACLE);
        // Placing elsewhere must leave the corner grain alone.
        enqueue_request(fsg_pkg::MODE_READ, 0, 0, fsg_pkg::KIND_EMPTY);
        enqueue_request(fsg_pkg::MODE_PLACE, 5, 5, fsg_pkg::KIND_UNDEF);
        enqueue_request(fsg_pkg::MODE_READ, 5, 5, fsg_pkg::KIND_EMPTY);
        enqueue_request(fsg_pkg::MODE_PLACE, 40, 3, fsg_pkg::KIND_SAND);
        enqueue_request(fsg_pkg::MODE_READ, 3, 40, fsg_pkg::KIND_EMPTY);
        enqueue_request(fsg_pkg::MODE_READ, 63, 63, fsg_pkg::KIND_UNDEF);
        enqueue_request(MODE_UNDEF, 63, 63, fsg_pkg::KIND_UNDEF);
        enqueue_request(fsg_pkg::MODE_PLACE, 39, 39, fsg_pkg::KIND_SAND);
        enqueue_request(fsg_pkg::MODE_FRAME, 0, 0, fsg_pkg::KIND_EMPTY);
        enqueue_request(fsg_pkg::MODE_READ, 0, 1, fsg_pkg::KIND_EMPTY);

        // Empty grid: nothing is in range, a frame still answers valid.
        set_grid_size(0);
        enqueue_request(fsg_pkg::MODE_PLACE, 0, 0, fsg_pkg::KIND_SAND);
        enqueue_request(fsg_pkg::MODE_FRAME, 0, 0, fsg_pkg::KIND_EMPTY);
        enqueue_request(fsg_pkg::MODE_READ, 0, 0, fsg_pkg::KIND_EMPTY);

        // Oversized register saturates; grain at the right edge falls left.
        set_grid_size(127);
        enqueue_request(fsg_pkg::MODE_PLACE, 63, 0, fsg_pkg::KIND_SAND);
        enqueue_request(fsg_pkg::MODE_PLACE, 63, 1, fsg_pkg::KIND_OBSTACLE);
        enqueue_request(fsg_pkg::MODE_FRAME, 63, 63, fsg_pkg::KIND_EMPTY);
        enqueue_request(fsg_pkg::MODE_READ, 62, 1, fsg_pkg::KIND_EMPTY);
        enqueue_request(fsg_pkg::MODE_READ, 63, 63, fsg_pkg::KIND_EMPTY);

        // Tiny grid: blocked grain takes the below-right cell.
        set_grid_size(3);
        enqueue_request(fsg_pkg::MODE_PLACE, 1, 0, fsg_pkg::KIND_SAND);
        enqueue_request(fsg_pkg::MODE_PLACE, 1, 1, fsg_pkg::KIND_OBSTACLE);
        enqueue_request(fsg_pkg::MODE_FRAME, 0, 0, fsg_pkg::KIND_EMPTY);
        enqueue_request(fsg_pkg::MODE_READ, 2, 1, fsg_pkg::KIND_EMPTY);

        // Random traffic across small, default and largest sizes.
        random_phase(1, 6);
        random_phase(2, 6);
        random_phase(5, 8);
        random_phase(8, 8);
        random_phase(16, 6);
        random_phase(64, 6);
        random_phase(65, 6);
        random_phase(40, 8);

        // Drain, then watch a little longer for stray responses.
        wait_for_quiet();
        repeat (20) @(negedge clk);
        if (answers_due.size() != 0)
            mismatches++;

        $display("Covered %0d requests: %0d places, %0d reads, %0d frames.",
                 queued_total, places_run, reads_run, frames_run);
        $display("Grid size written %0d times, from 0 to 127; %0d mismatches.",
                 sizes_written, mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
